// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the controller of the vertical advection column RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// A condition that must hold at every clock edge out of reset.
`define VMA_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
// A condition that must hold in the cycle after a trigger.
`define VMA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define VMA_ASSERT(lbl, cond, msg)
`define VMA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/core/vma_pkg.sv -----
// Shared types, codes and constants of the vertical advection column.
package vma_pkg;

	localparam int QW         = 48;
	localparam int LS_W       = 47;
	localparam int LEVELS_DEF = 64;
	localparam int CFG_IDX_W  = 1;
	localparam int OUT_LVL_W  = 8;

	typedef logic signed [QW-1:0] q_t;

	localparam q_t QMAX = 48'sh7FFF_FFFF_FFFF;
	localparam q_t QMIN = 48'sh8000_0000_0000;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_LAYER_SCALE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THREE_D     = 1'd1;

	// Arithmetic unit operations.
	localparam logic OP_MUL = 1'b0;
	localparam logic OP_DIV = 1'b1;

	// Operand sources.
	typedef logic [4:0] src_t;
	localparam src_t SRC_C30      = 5'd0;
	localparam src_t SRC_LS       = 5'd1;
	localparam src_t SRC_D        = 5'd2;
	localparam src_t SRC_RHOW     = 5'd3;
	localparam src_t SRC_RHOI     = 5'd4;
	localparam src_t SRC_WU       = 5'd5;
	localparam src_t SRC_WV       = 5'd6;
	localparam src_t SRC_T        = 5'd7;
	localparam src_t SRC_SUMU     = 5'd8;
	localparam src_t SRC_SUMV     = 5'd9;
	localparam src_t SRC_W        = 5'd10;
	localparam src_t SRC_LASTW    = 5'd11;
	localparam src_t SRC_LASTRHOW = 5'd12;
	localparam src_t SRC_P1T      = 5'd13;
	localparam src_t SRC_SUMW     = 5'd14;
	localparam src_t SRC_DIFU     = 5'd15;
	localparam src_t SRC_DIFV     = 5'd16;
	localparam src_t SRC_DIFW     = 5'd17;
	localparam src_t SRC_LLF      = 5'd18;
	localparam src_t SRC_LIF      = 5'd19;
	localparam src_t SRC_RHO      = 5'd20;
	localparam src_t SRC_ADZ      = 5'd21;
	localparam src_t SRC_ADZW     = 5'd22;

	// Result destinations.
	typedef logic [3:0] dst_t;
	localparam dst_t DST_D    = 4'd0;
	localparam dst_t DST_RHOI = 4'd1;
	localparam dst_t DST_T    = 4'd2;
	localparam dst_t DST_FU   = 4'd3;
	localparam dst_t DST_FV   = 4'd4;
	localparam dst_t DST_P1   = 4'd5;
	localparam dst_t DST_FW   = 4'd6;
	localparam dst_t DST_DU   = 4'd7;
	localparam dst_t DST_DV   = 4'd8;
	localparam dst_t DST_DW   = 4'd9;
	localparam dst_t DST_LLF  = 4'd10;
	localparam dst_t DST_LIF  = 4'd11;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;
		logic op;
		src_t src_a;
		src_t src_b;
		dst_t dst;
		logic load_in;
		logic zero_fuv;
		logic zero_fw;
		logic zero_dw;
		logic ram_rd;
		logic sum_cap;
		logic commit;
		logic emit;
		logic last;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic busy;
		logic done;
		logic out_free;
	} sts_t;

endpackage

// ----- rtl/core/vertical_momentum_advection_column.sv -----
// Top level of the vertical momentum advection column block.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_stall   | winds, densities, thicknesses, flags
//   out     | output    | out_valid / out_stall | level_index, changes, flux totals, done
//   cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// A new item is taken only once the controller is back in idle. A bottom item
// runs the two layer-factor multiplies, a top item skips the horizontal fluxes
// and level one skips the vertical divide. The single shared unit sets the pace:
// up to four bit-serial divides and eleven four-step multiplies. Reset clears
// the column state and sets layer_scale to 1.0 and three-dimensional mode; the
// flux sum memories are not cleared. A held result does not block the next
// transfer in; the result after it waits until the output register is free.
module vertical_momentum_advection_column
	import vma_pkg::*;
#(
	parameter int LEVELS = LEVELS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LS_W-1:0]      cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  q_t                   u_wind,
	input  q_t                   v_wind,
	input  q_t                   w_wind,
	input  q_t                   w_west,
	input  q_t                   w_south,
	input  q_t                   interface_density,
	input  q_t                   layer_density,
	input  q_t                   layer_thickness,
	input  q_t                   interface_thickness,
	input  logic                 first_column,
	input  logic                 top_level,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [OUT_LVL_W-1:0] level_index,
	output q_t                   u_change,
	output q_t                   v_change,
	output q_t                   w_change,
	output q_t                   u_flux_total,
	output q_t                   v_flux_total,
	output logic                 column_done
);

	localparam int LVL_W = $clog2(LEVELS);

	cmd_t             cmd;
	sts_t             sts;
	logic [LVL_W-1:0] level;

	// Step sequencer.
	vma_ctrl #(.LEVELS(LEVELS), .LVL_W(LVL_W)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.top_level (top_level),
		.in_stall  (in_stall),
		.level     (level),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Arithmetic, column state and flux sums.
	vma_dp #(.LEVELS(LEVELS), .LVL_W(LVL_W)) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.u_wind              (u_wind),
		.v_wind              (v_wind),
		.w_wind              (w_wind),
		.w_west              (w_west),
		.w_south             (w_south),
		.interface_density   (interface_density),
		.layer_density       (layer_density),
		.layer_thickness     (layer_thickness),
		.interface_thickness (interface_thickness),
		.first_column        (first_column),
		.out_stall           (out_stall),
		.out_valid           (out_valid),
		.level_index         (level_index),
		.u_change            (u_change),
		.v_change            (v_change),
		.w_change            (w_change),
		.u_flux_total        (u_flux_total),
		.v_flux_total        (v_flux_total),
		.column_done         (column_done),
		.level               (level),
		.cmd                 (cmd),
		.sts                 (sts)
	);

endmodule

// ----- rtl/core/vma_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module vma_ram #(
	parameter int W      = 48,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [W-1:0]      wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [W-1:0]      rdata
);

	logic [W-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/core/vma_ctrl.sv -----
// Controller state machine that sequences the arithmetic of one level.
module vma_ctrl
	import vma_pkg::*;
#(
	parameter int LEVELS = LEVELS_DEF,
	parameter int LVL_W  = $clog2(LEVELS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             top_level,
	output logic             in_stall,
	output logic [LVL_W-1:0] level,
	output cmd_t             cmd,
	input  sts_t             sts
);

	`include "assert_macros.svh"

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_D      = 5'd1;
	localparam logic [4:0] S_RHOI   = 5'd2;
	localparam logic [4:0] S_TU     = 5'd3;
	localparam logic [4:0] S_FU     = 5'd4;
	localparam logic [4:0] S_TV     = 5'd5;
	localparam logic [4:0] S_FV     = 5'd6;
	localparam logic [4:0] S_ZFUV   = 5'd7;
	localparam logic [4:0] S_P1     = 5'd8;
	localparam logic [4:0] S_P2     = 5'd9;
	localparam logic [4:0] S_T3     = 5'd10;
	localparam logic [4:0] S_FW     = 5'd11;
	localparam logic [4:0] S_DU     = 5'd12;
	localparam logic [4:0] S_DV     = 5'd13;
	localparam logic [4:0] S_DW     = 5'd14;
	localparam logic [4:0] S_ZDW    = 5'd15;
	localparam logic [4:0] S_RD     = 5'd16;
	localparam logic [4:0] S_SUM    = 5'd17;
	localparam logic [4:0] S_LF     = 5'd18;
	localparam logic [4:0] S_IF     = 5'd19;
	localparam logic [4:0] S_ZERO   = 5'd20;
	localparam logic [4:0] S_COMMIT = 5'd21;
	localparam logic [4:0] S_EMIT   = 5'd22;

	localparam logic [LVL_W-1:0] K_ZERO = '0;
	localparam logic [LVL_W-1:0] K_ONE  = LVL_W'(1);
	localparam logic [LVL_W-1:0] K_TOP  = LVL_W'(LEVELS - 1);

	logic [4:0]       state_q;
	logic [4:0]       nxt;
	logic             issued_q;
	logic             unit_st;
	logic             adv;
	logic [LVL_W-1:0] k_q;
	logic             top_q;
	logic             finish;

	function automatic cmd_t unit_cmd(logic op, src_t a, src_t b, dst_t d);
		cmd_t c;
		c       = '0;
		c.op    = op;
		c.src_a = a;
		c.src_b = b;
		c.dst   = d;
		return c;
	endfunction

	// Next state, command and advance condition for each step.
	always_comb begin
		cmd     = '0;
		nxt     = S_IDLE;
		unit_st = 1'b0;
		adv     = 1'b1;
		finish  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load_in = in_valid;
				adv         = in_valid;
				nxt         = (k_q == K_ZERO) ? S_LF : S_D;
			end
			S_D: begin
				cmd     = unit_cmd(OP_DIV, SRC_C30, SRC_LS, DST_D);
				unit_st = 1'b1;
				nxt     = top_q ? S_ZFUV : S_RHOI;
			end
			S_RHOI: begin
				cmd     = unit_cmd(OP_MUL, SRC_D, SRC_RHOW, DST_RHOI);
				unit_st = 1'b1;
				nxt     = S_TU;
			end
			S_TU: begin
				cmd     = unit_cmd(OP_MUL, SRC_RHOI, SRC_WU, DST_T);
				unit_st = 1'b1;
				nxt     = S_FU;
			end
			S_FU: begin
				cmd     = unit_cmd(OP_MUL, SRC_T, SRC_SUMU, DST_FU);
				unit_st = 1'b1;
				nxt     = S_TV;
			end
			S_TV: begin
				cmd     = unit_cmd(OP_MUL, SRC_RHOI, SRC_WV, DST_T);
				unit_st = 1'b1;
				nxt     = S_FV;
			end
			S_FV: begin
				cmd     = unit_cmd(OP_MUL, SRC_T, SRC_SUMV, DST_FV);
				unit_st = 1'b1;
				nxt     = S_P1;
			end
			S_ZFUV: begin
				cmd.zero_fuv = 1'b1;
				nxt          = S_P1;
			end
			S_P1: begin
				cmd     = unit_cmd(OP_MUL, SRC_W, SRC_RHOW, DST_P1);
				unit_st = 1'b1;
				nxt     = S_P2;
			end
			S_P2: begin
				cmd     = unit_cmd(OP_MUL, SRC_LASTW, SRC_LASTRHOW, DST_T);
				unit_st = 1'b1;
				nxt     = S_T3;
			end
			S_T3: begin
				cmd     = unit_cmd(OP_MUL, SRC_D, SRC_P1T, DST_T);
				unit_st = 1'b1;
				nxt     = S_FW;
			end
			S_FW: begin
				cmd     = unit_cmd(OP_MUL, SRC_T, SRC_SUMW, DST_FW);
				unit_st = 1'b1;
				nxt     = S_DU;
			end
			S_DU: begin
				cmd     = unit_cmd(OP_DIV, SRC_DIFU, SRC_LLF, DST_DU);
				unit_st = 1'b1;
				nxt     = S_DV;
			end
			S_DV: begin
				cmd     = unit_cmd(OP_DIV, SRC_DIFV, SRC_LLF, DST_DV);
				unit_st = 1'b1;
				nxt     = (k_q > K_ONE) ? S_DW : S_ZDW;
			end
			S_DW: begin
				cmd     = unit_cmd(OP_DIV, SRC_DIFW, SRC_LIF, DST_DW);
				unit_st = 1'b1;
				nxt     = S_RD;
			end
			S_ZDW: begin
				cmd.zero_dw = 1'b1;
				nxt         = S_RD;
			end
			S_RD: begin
				cmd.ram_rd = 1'b1;
				nxt        = S_SUM;
			end
			S_SUM: begin
				cmd.sum_cap = 1'b1;
				nxt         = S_LF;
			end
			S_LF: begin
				cmd     = unit_cmd(OP_MUL, SRC_RHO, SRC_ADZ, DST_LLF);
				unit_st = 1'b1;
				nxt     = S_IF;
			end
			S_IF: begin
				cmd     = unit_cmd(OP_MUL, SRC_RHOW, SRC_ADZW, DST_LIF);
				unit_st = 1'b1;
				nxt     = (k_q == K_ZERO) ? S_ZERO : S_EMIT;
			end
			S_ZERO: begin
				cmd.zero_fuv = 1'b1;
				cmd.zero_fw  = 1'b1;
				nxt          = S_COMMIT;
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				finish     = 1'b1;
			end
			S_EMIT: begin
				adv        = sts.out_free;
				cmd.commit = sts.out_free;
				cmd.emit   = sts.out_free;
				finish     = sts.out_free;
			end
			default: begin
				nxt = S_IDLE;
			end
		endcase
		if (unit_st) begin
			cmd.start = !issued_q;
			adv       = issued_q && sts.done;
		end
		cmd.last = top_q;
	end

	assign in_stall = (state_q != S_IDLE);
	assign level    = k_q;

	// State register, issue flag and level counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			issued_q <= 1'b0;
			k_q      <= K_ZERO;
			top_q    <= 1'b0;
		end else begin
			if (unit_st && !issued_q) begin
				issued_q <= 1'b1;
			end else if (adv) begin
				issued_q <= 1'b0;
			end
			if (adv) begin
				state_q <= nxt;
			end
			if (state_q == S_IDLE && in_valid) begin
				top_q <= top_level || (k_q == K_TOP);
			end
			if (finish) begin
				k_q <= top_q ? K_ZERO : k_q + K_ONE;
			end
		end
	end

	`VMA_ASSERT(a_start_unit_free, !(cmd.start && sts.busy), "unit started while busy")
	`VMA_ASSERT(a_done_expected, !(sts.done && !issued_q), "unit finished without a request")
	`VMA_ASSERT(a_emit_slot, !(cmd.emit && !sts.out_free), "result loaded over a held one")
	`VMA_ASSERT_NEXT(a_accept_leaves_idle, in_valid && !in_stall, state_q != S_IDLE, "transfer left controller idle")

endmodule

// ----- rtl/core/vma_dp.sv -----
// Datapath: operand selection, shared multiply and divide unit, flux sums.
module vma_dp
	import vma_pkg::*;
#(
	parameter int LEVELS = LEVELS_DEF,
	parameter int LVL_W  = $clog2(LEVELS)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LS_W-1:0]      cfg_data,
	input  q_t                   u_wind,
	input  q_t                   v_wind,
	input  q_t                   w_wind,
	input  q_t                   w_west,
	input  q_t                   w_south,
	input  q_t                   interface_density,
	input  q_t                   layer_density,
	input  q_t                   layer_thickness,
	input  q_t                   interface_thickness,
	input  logic                 first_column,
	input  logic                 out_stall,
	output logic                 out_valid,
	output logic [OUT_LVL_W-1:0] level_index,
	output q_t                   u_change,
	output q_t                   v_change,
	output q_t                   w_change,
	output q_t                   u_flux_total,
	output q_t                   v_flux_total,
	output logic                 column_done,
	input  logic [LVL_W-1:0]     level,
	input  cmd_t                 cmd,
	output sts_t                 sts
);

	localparam logic [6:0]      MUL_LAST = 7'd4;
	localparam logic [6:0]      DIV_LAST = 7'd80;
	localparam logic [LS_W-1:0] LS_RESET = 47'h0001_0000_0000;
	localparam q_t              C30      = 48'sh0000_4000_0000;
	localparam logic [50:0]     QCAP     = {1'b1, 50'd0};
	localparam logic [63:0]     MLIM     = 64'h0000_8000_0000_0000;

	// Configuration.
	logic [LS_W-1:0] ls_q;
	logic            mode_q;

	// Latched input item.
	q_t   u_q, v_q, w_q, ww_q, ws_q, rhow_q, rho_q, adz_q, adzw_q;
	logic first_q;

	// Column state carried between levels.
	q_t last_u_q, last_v_q, last_w_q, last_rhow_q;
	q_t llf_q, lif_q, luf_q, lvf_q, lwf_q;

	// Intermediate values of the current level.
	q_t d_q, rhoi_q, t_q, p1_q, fu_q, fv_q, fw_q, du_q, dv_q, dw_q, su_q, sv_q;

	// Arithmetic unit.
	logic        busy_q;
	logic        op_q;
	dst_t        dst_q;
	logic [6:0]  cnt_q;
	logic [47:0] ma_q, mb_q, sh_q, rem_q;
	logic        neg_q, bz_q, az_q, aneg_q;
	logic [95:0] acc_q;
	logic [50:0] quo_q;
	logic        fin;
	q_t          res;

	q_t          opa, opb;
	q_t          wu, wv, sumu, sumv, sumw, p1t, difu, difv, difw;
	logic [47:0] mag_a, mag_b;
	logic [23:0] ah, bh;
	logic [47:0] pp;
	logic [95:0] pps;
	logic [48:0] r2;
	logic        ge;
	logic [51:0] qs;
	logic        rnd;
	logic [63:0] mr;

	q_t   ru_rdata, rv_rdata;
	logic out_valid_q;

	function automatic q_t sat_add(q_t a, q_t b);
		logic signed [QW:0] s;
		s = {a[QW-1], a} + {b[QW-1], b};
		if (s[QW] != s[QW-1]) begin
			return s[QW] ? QMIN : QMAX;
		end
		return s[QW-1:0];
	endfunction

	function automatic q_t sat_sub(q_t a, q_t b);
		logic signed [QW:0] s;
		s = {a[QW-1], a} - {b[QW-1], b};
		if (s[QW] != s[QW-1]) begin
			return s[QW] ? QMIN : QMAX;
		end
		return s[QW-1:0];
	endfunction

	function automatic logic [47:0] mag(q_t a);
		logic [47:0] ua;
		ua = a;
		return ua[47] ? (~ua + 48'd1) : ua;
	endfunction

	// Applies a sign to a magnitude and saturates to the Q16.32 range.
	function automatic q_t sat_signed(logic [63:0] m, logic neg);
		logic [63:0] mm;
		mm = m;
		if (neg) begin
			if (mm > MLIM) begin
				mm = MLIM;
			end
			return q_t'(~mm[47:0] + 48'd1);
		end
		if (mm > {16'd0, QMAX}) begin
			return QMAX;
		end
		return q_t'(mm[47:0]);
	endfunction

	// Saturating sums and differences that feed the unit.
	always_comb begin
		wu   = sat_add(w_q, ww_q);
		wv   = mode_q ? sat_add(w_q, ws_q) : wu;
		sumu = sat_add(u_q, last_u_q);
		sumv = sat_add(v_q, last_v_q);
		sumw = sat_add(w_q, last_w_q);
		p1t  = sat_add(p1_q, t_q);
		difu = sat_sub(luf_q, fu_q);
		difv = sat_sub(lvf_q, fv_q);
		difw = sat_sub(lwf_q, fw_q);
	end

	function automatic q_t operand(src_t s);
		q_t r;
		unique case (s)
			SRC_C30:      r = C30;
			SRC_LS:       r = q_t'({1'b0, ls_q});
			SRC_D:        r = d_q;
			SRC_RHOW:     r = rhow_q;
			SRC_RHOI:     r = rhoi_q;
			SRC_WU:       r = wu;
			SRC_WV:       r = wv;
			SRC_T:        r = t_q;
			SRC_SUMU:     r = sumu;
			SRC_SUMV:     r = sumv;
			SRC_W:        r = w_q;
			SRC_LASTW:    r = last_w_q;
			SRC_LASTRHOW: r = last_rhow_q;
			SRC_P1T:      r = p1t;
			SRC_SUMW:     r = sumw;
			SRC_DIFU:     r = difu;
			SRC_DIFV:     r = difv;
			SRC_DIFW:     r = difw;
			SRC_LLF:      r = llf_q;
			SRC_LIF:      r = lif_q;
			SRC_RHO:      r = rho_q;
			SRC_ADZ:      r = adz_q;
			SRC_ADZW:     r = adzw_q;
			default:      r = '0;
		endcase
		return r;
	endfunction

	always_comb begin
		opa   = operand(cmd.src_a);
		opb   = operand(cmd.src_b);
		mag_a = mag(opa);
		mag_b = mag(opb);
	end

	// One 24 by 24 partial product per multiply step.
	always_comb begin
		ah = cnt_q[0] ? ma_q[47:24] : ma_q[23:0];
		bh = cnt_q[1] ? mb_q[47:24] : mb_q[23:0];
		pp = ah * bh;
		unique case (cnt_q[1:0])
			2'b00:        pps = {48'd0, pp};
			2'b01, 2'b10: pps = {24'd0, pp, 24'd0};
			2'b11:        pps = {pp, 48'd0};
			default:      pps = {48'd0, pp};
		endcase
	end

	// One restoring step per divide step, quotient held at its cap.
	always_comb begin
		r2  = {rem_q, sh_q[47]};
		ge  = (r2 >= {1'b0, mb_q});
		qs  = {quo_q, ge};
		rnd = ({rem_q, 1'b0} >= {1'b0, mb_q});
		mr  = acc_q[95:32] + {63'd0, acc_q[31]};
	end

	// Final rounding and saturation of the unit's result.
	always_comb begin
		fin = busy_q && (cnt_q == ((op_q == OP_MUL) ? MUL_LAST : DIV_LAST));
		if (op_q == OP_MUL) begin
			res = sat_signed(mr, neg_q);
		end else if (bz_q) begin
			res = az_q ? '0 : (aneg_q ? QMIN : QMAX);
		end else begin
			res = sat_signed({13'd0, quo_q} + {63'd0, rnd}, neg_q);
		end
	end

	// Unit control and iteration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= OP_MUL;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			op_q   <= cmd.op;
		end else if (fin) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			dst_q  <= cmd.dst;
			ma_q   <= mag_a;
			mb_q   <= mag_b;
			sh_q   <= mag_a;
			neg_q  <= opa[QW-1] ^ opb[QW-1];
			bz_q   <= (opb == '0);
			az_q   <= (opa == '0);
			aneg_q <= opa[QW-1];
			acc_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
		end else if (busy_q && !fin) begin
			if (op_q == OP_MUL) begin
				acc_q <= acc_q + pps;
			end else begin
				sh_q  <= {sh_q[46:0], 1'b0};
				rem_q <= ge ? 48'(r2 - {1'b0, mb_q}) : r2[47:0];
				quo_q <= (qs > {1'b0, QCAP}) ? QCAP : qs[50:0];
			end
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ls_q   <= LS_RESET;
			mode_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LAYER_SCALE: ls_q   <= cfg_data;
				REG_THREE_D:     mode_q <= cfg_data[0];
				default:         mode_q <= mode_q;
			endcase
		end
	end

	// Input item capture on transfer.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			u_q     <= u_wind;
			v_q     <= v_wind;
			w_q     <= w_wind;
			ww_q    <= w_west;
			ws_q    <= w_south;
			rhow_q  <= interface_density;
			rho_q   <= layer_density;
			adz_q   <= layer_thickness;
			adzw_q  <= interface_thickness;
			first_q <= first_column;
		end
	end

	// Intermediate results written by the unit or cleared by command.
	always_ff @(posedge clk) begin
		if (fin) begin
			unique case (dst_q)
				DST_D:    d_q    <= res;
				DST_RHOI: rhoi_q <= res;
				DST_T:    t_q    <= res;
				DST_FU:   fu_q   <= res;
				DST_FV:   fv_q   <= res;
				DST_P1:   p1_q   <= res;
				DST_FW:   fw_q   <= res;
				DST_DU:   du_q   <= res;
				DST_DV:   dv_q   <= res;
				DST_DW:   dw_q   <= res;
				default:  t_q    <= t_q;
			endcase
		end
		if (cmd.zero_fuv) begin
			fu_q <= '0;
			fv_q <= '0;
		end
		if (cmd.zero_fw) begin
			fw_q <= '0;
		end
		if (cmd.zero_dw) begin
			dw_q <= '0;
		end
		if (cmd.sum_cap) begin
			su_q <= first_q ? fu_q : sat_add(ru_rdata, fu_q);
			sv_q <= first_q ? fv_q : sat_add(rv_rdata, fv_q);
		end
	end

	// Column state: layer factors from the unit, the rest on commit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_u_q    <= '0;
			last_v_q    <= '0;
			last_w_q    <= '0;
			last_rhow_q <= '0;
			llf_q       <= '0;
			lif_q       <= '0;
			luf_q       <= '0;
			lvf_q       <= '0;
			lwf_q       <= '0;
		end else begin
			if (fin && dst_q == DST_LLF) begin
				llf_q <= res;
			end
			if (fin && dst_q == DST_LIF) begin
				lif_q <= res;
			end
			if (cmd.commit) begin
				last_u_q    <= u_q;
				last_v_q    <= v_q;
				last_w_q    <= w_q;
				last_rhow_q <= rhow_q;
				luf_q       <= fu_q;
				lvf_q       <= fv_q;
				lwf_q       <= fw_q;
			end
		end
	end

	// Flux sums per interface.
	vma_ram #(.W(QW), .DEPTH(LEVELS)) u_sum_ram (
		.clk   (clk),
		.we    (cmd.emit),
		.waddr (level),
		.wdata (su_q),
		.re    (cmd.ram_rd),
		.raddr (level),
		.rdata (ru_rdata)
	);

	vma_ram #(.W(QW), .DEPTH(LEVELS)) v_sum_ram (
		.clk   (clk),
		.we    (cmd.emit),
		.waddr (level),
		.wdata (sv_q),
		.re    (cmd.ram_rd),
		.raddr (level),
		.rdata (rv_rdata)
	);

	// Output register: held until the downstream transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			level_index  <= OUT_LVL_W'(level - LVL_W'(1));
			u_change     <= du_q;
			v_change     <= dv_q;
			w_change     <= dw_q;
			u_flux_total <= su_q;
			v_flux_total <= sv_q;
			column_done  <= cmd.last;
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.busy     = busy_q;
	assign sts.done     = fin;
	assign sts.out_free = !out_valid_q || !out_stall;

endmodule

// ----- test/vertical_momentum_advection_column_tb.sv -----
// Self-checking testbench for the vertical momentum advection column block.
module vertical_momentum_advection_column_tb;
	import vma_pkg::*;

	localparam int NLEV      = LEVELS_DEF;
	localparam int ITEMS     = 1700;
	localparam int SETTLE    = 600;
	localparam longint LIMIT = 4000000;

	// Input payload of one level.
	typedef struct {
		q_t u, v, w, ww, ws, rhow, rho, adz, adzw;
		bit first, top;
	} level_item_t;

	// Tendency changes and flux totals of one level.
	typedef struct {
		logic [OUT_LVL_W-1:0] lvl;
		q_t du, dv, dw, su, sv;
		bit done;
	} tendency_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [LS_W-1:0] cfg_data;
	logic in_valid, in_stall;
	q_t u_wind, v_wind, w_wind, w_west, w_south;
	q_t interface_density, layer_density, layer_thickness, interface_thickness;
	logic first_column, top_level;
	logic out_valid, out_stall;
	logic [OUT_LVL_W-1:0] level_index;
	q_t u_change, v_change, w_change, u_flux_total, v_flux_total;
	logic column_done;

	vertical_momentum_advection_column #(.LEVELS(NLEV)) dut (.*);

	// Predictor state: configuration and column history.
	longint unsigned scale_q;
	bit three_d;
	longint prev_u, prev_v, prev_w, prev_rhow, prev_layer_f, prev_iface_f;
	longint prev_fu, prev_fv, prev_fw;
	int lvl;
	longint u_sums [NLEV];
	longint v_sums [NLEV];
	bit sum_written [NLEV];

	tendency_t pending_tendencies[$];
	int errors, items_sent, results_seen, columns_sent;
	longint cycles;
	bit quiet;
	int stall_left;

	// Clock, cycle limit.
	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL vertical_momentum_advection_column");
			$finish;
		end
	end

	// Saturating fixed-point arithmetic of the datapath.
	function automatic longint clampq(longint x);
		if (x > longint'(QMAX)) return longint'(QMAX);
		if (x < longint'(QMIN)) return longint'(QMIN);
		return x;
	endfunction

	function automatic longint signq(longint unsigned m, bit neg);
		if (neg) begin
			if (m > (64'd1 << 47)) m = 64'd1 << 47;
			return -longint'(m);
		end
		if (m > 64'h7FFF_FFFF_FFFF) m = 64'h7FFF_FFFF_FFFF;
		return longint'(m);
	endfunction

	function automatic longint unsigned magq(longint a);
		return a < 0 ? longint'(-a) : a;
	endfunction

	function automatic longint mulq(longint a, longint b);
		logic [127:0] p;
		longint unsigned r;
		p = 128'(magq(a)) * 128'(magq(b));
		r = 64'(p >> 32) + 64'(p[31]);
		return signq(r, (a < 0) != (b < 0));
	endfunction

	function automatic longint divq(longint a, longint b);
		longint unsigned ua, ub, q, r, b_in;
		if (b == 0) return a > 0 ? longint'(QMAX) : (a < 0 ? longint'(QMIN) : 0);
		ua = magq(a);
		ub = magq(b);
		q = 0;
		r = 0;
		for (int i = 79; i >= 0; i--) begin
			b_in = i >= 32 ? (ua >> (i - 32)) & 64'd1 : 64'd0;
			r = (r << 1) | b_in;
			q = q << 1;
			if (r >= ub) begin
				r = r - ub;
				q = q | 64'd1;
			end
			if (q > (64'd1 << 50)) q = 64'd1 << 50;
		end
		if (2 * r >= ub) q++;
		return signq(q, (a < 0) != (b < 0));
	endfunction

	function automatic longint quarter_over_dz();
		longint unsigned q;
		if (scale_q == 0) return longint'(QMAX);
		q = ((64'd1 << 62) + (scale_q >> 1)) / scale_q;
		return q > 64'h7FFF_FFFF_FFFF ? longint'(QMAX) : longint'(q);
	endfunction

	// Works out the tendency changes caused by one accepted level.
	task automatic advect_level(level_item_t it);
		longint d, fu, fv, fw, rhoi, wu, wv, su, sv, dw;
		int k;
		bit top;
		tendency_t t;
		k = lvl;
		top = it.top || k >= NLEV - 1;
		d = quarter_over_dz();
		fu = 0;
		fv = 0;
		dw = 0;
		if (k != 0) begin
			if (!top) begin
				rhoi = mulq(d, it.rhow);
				wu = clampq(it.w + it.ww);
				wv = three_d ? clampq(it.w + it.ws) : wu;
				fu = mulq(mulq(rhoi, wu), clampq(it.u + prev_u));
				fv = mulq(mulq(rhoi, wv), clampq(it.v + prev_v));
			end
			fw = mulq(mulq(d, clampq(mulq(it.w, it.rhow) + mulq(prev_w, prev_rhow))),
				clampq(it.w + prev_w));
			t.du = divq(clampq(prev_fu - fu), prev_layer_f);
			t.dv = divq(clampq(prev_fv - fv), prev_layer_f);
			if (k > 1) dw = divq(clampq(prev_fw - fw), prev_iface_f);
			t.dw = dw;
			su = it.first ? fu : clampq(u_sums[k] + fu);
			sv = it.first ? fv : clampq(v_sums[k] + fv);
			u_sums[k] = su;
			v_sums[k] = sv;
			sum_written[k] = 1'b1;
			t.su = su;
			t.sv = sv;
			t.lvl = k - 1;
			t.done = top;
			pending_tendencies.push_back(t);
			prev_fw = fw;
		end else begin
			prev_fw = 0;
		end
		prev_u = it.u;
		prev_v = it.v;
		prev_w = it.w;
		prev_rhow = it.rhow;
		prev_layer_f = mulq(it.rho, it.adz);
		prev_iface_f = mulq(it.rhow, it.adzw);
		prev_fu = fu;
		prev_fv = fv;
		lvl = top ? 0 : k + 1;
	endtask

	// Mismatch reporting.
	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	// Result side: random stall bursts, driven at the rising edge.
	always @(posedge clk) begin
		bit s;
		if (quiet || !arst_n) begin
			s = 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			s = 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			s = 1'b1;
			stall_left <= $urandom_range(0, 11);
		end else begin
			s = 1'b0;
		end
		out_stall <= s;
	end

	// Result checking; inputs settle between edges so the falling edge is safe.
	always @(negedge clk) begin
		tendency_t t;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_tendencies.size() == 0) begin
				report_mismatch("unexpected result, level", level_index, 0);
			end else begin
				t = pending_tendencies.pop_front();
				if (level_index !== t.lvl) report_mismatch("level_index", level_index, t.lvl);
				if (u_change !== t.du) report_mismatch("u_change", u_change, t.du);
				if (v_change !== t.dv) report_mismatch("v_change", v_change, t.dv);
				if (w_change !== t.dw) report_mismatch("w_change", w_change, t.dw);
				if (u_flux_total !== t.su)
					report_mismatch("u_flux_total", u_flux_total, t.su);
				if (v_flux_total !== t.sv)
					report_mismatch("v_flux_total", v_flux_total, t.sv);
				if (column_done !== t.done) report_mismatch("column_done", column_done, t.done);
			end
		end
	end

	// Sends one level and returns just after the edge of its transfer.
	task automatic send_level(level_item_t it);
		bit taken;
		in_valid <= 1'b1;
		u_wind <= it.u;
		v_wind <= it.v;
		w_wind <= it.w;
		w_west <= it.ww;
		w_south <= it.ws;
		interface_density <= it.rhow;
		layer_density <= it.rho;
		layer_thickness <= it.adz;
		interface_thickness <= it.adzw;
		first_column <= it.first;
		top_level <= it.top;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		advect_level(it);
		items_sent++;
	endtask

	task automatic idle_inputs(int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Waits until every result has arrived and the block has settled.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_tendencies.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint unsigned value);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[LS_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_LAYER_SCALE) scale_q = value & 64'h7FFF_FFFF_FFFF;
		else if (idx == REG_THREE_D) three_d = value[0];
	endtask

	// Field values: 0 near unity, 1 any pattern, 2 extremes, 3 zero.
	function automatic q_t pick_q(int kind);
		logic [63:0] x;
		logic signed [35:0] near;
		x = {$urandom, $urandom};
		near = x[35:0];
		case (kind)
			0: return near;
			1: return x[47:0];
			2: case ($urandom_range(0, 4))
				0: return QMAX;
				1: return QMIN;
				2: return '0;
				3: return -48'sd1;
				default: return 48'sd1;
			endcase
			default: return '0;
		endcase
	endfunction

	function automatic int pick_kind();
		int r;
		r = $urandom_range(0, 9);
		return r < 7 ? 0 : (r < 9 ? 1 : 2);
	endfunction

	// Sends one column; kind < 0 mixes value kinds per field.
	task automatic send_column(int height, bit first, int kind, bit noisy, bit zero_div);
		level_item_t it;
		for (int j = 0; j < height; j++) begin
			it.u = pick_q(kind < 0 ? pick_kind() : kind);
			it.v = pick_q(kind < 0 ? pick_kind() : kind);
			it.w = pick_q(kind < 0 ? pick_kind() : kind);
			it.ww = pick_q(kind < 0 ? pick_kind() : kind);
			it.ws = pick_q(kind < 0 ? pick_kind() : kind);
			it.rhow = pick_q(kind < 0 ? pick_kind() : kind);
			it.rho = pick_q(kind < 0 ? pick_kind() : kind);
			it.adz = pick_q(kind < 0 ? pick_kind() : kind);
			it.adzw = pick_q(kind < 0 ? pick_kind() : kind);
			if (zero_div) begin
				if ($urandom_range(0, 1)) it.rho = '0;
				else it.adz = '0;
				if ($urandom_range(0, 1)) it.adzw = '0;
			end
			it.first = noisy && $urandom_range(0, 19) == 0 ? !first : first;
			// A sum that was never written must not be read.
			if (lvl >= 1 && !sum_written[lvl]) it.first = 1'b1;
			it.top = noisy ? $urandom_range(0, 15) == 0 : j == height - 1;
			if (height >= NLEV && j == height - 1) it.top = $urandom_range(0, 1);
			send_level(it);
			if (!quiet && $urandom_range(0, 4) == 0) idle_inputs($urandom_range(1, 12));
		end
		columns_sent++;
	endtask

	// Directed checks.
	task automatic test_reset_defaults();
		send_column(4, 1'b1, 0, 1'b0, 1'b0);
		send_column(4, 1'b0, 0, 1'b0, 1'b0);
	endtask

	task automatic test_top_on_bottom();
		send_column(1, 1'b0, 0, 1'b0, 1'b0);
		send_column(2, 1'b1, 0, 1'b0, 1'b0);
	endtask

	task automatic test_extremes();
		send_column(4, 1'b0, 2, 1'b0, 1'b0);
		send_column(3, 1'b0, 1, 1'b0, 1'b0);
	endtask

	task automatic test_zero_divisor();
		send_column(3, 1'b0, 0, 1'b0, 1'b1);
	endtask

	task automatic test_config_extremes();
		write_reg(REG_THREE_D, 0);
		send_column(2, 1'b0, 0, 1'b0, 1'b0);
		write_reg(REG_LAYER_SCALE, 1);
		send_column(2, 1'b0, 0, 1'b0, 1'b0);
		write_reg(REG_LAYER_SCALE, 64'h7FFF_FFFF_FFFF);
		write_reg(REG_THREE_D, 1);
		send_column(2, 1'b0, 0, 1'b0, 1'b0);
		write_reg(REG_LAYER_SCALE, 0);
		send_column(2, 1'b0, 0, 1'b0, 1'b0);
	endtask

	// Columns reaching the top level, where the block forces the end.
	task automatic test_tall_columns();
		write_reg(REG_LAYER_SCALE, 64'd1 << 32);
		send_column(NLEV, 1'b1, 0, 1'b0, 1'b0);
		send_column(NLEV, 1'b0, -1, 1'b0, 1'b0);
	endtask

	// Random columns in phases, with a new setting between phases.
	task automatic test_random_sweeps();
		int phase_end;
		longint unsigned s;
		while (items_sent < ITEMS) begin
			case ($urandom_range(0, 4))
				0: s = 1;
				1: s = 64'h7FFF_FFFF_FFFF;
				2: s = 64'd1 << 32;
				default: s = {$urandom_range(0, 32767), $urandom};
			endcase
			write_reg(REG_LAYER_SCALE, s);
			write_reg(REG_THREE_D, $urandom_range(0, 1));
			phase_end = items_sent + 300;
			if (items_sent >= ITEMS - 250) quiet = 1'b1;
			while (items_sent < phase_end && items_sent < ITEMS) begin
				if ($urandom_range(0, 9) == 0)
					send_column($urandom_range(1, 20), $urandom_range(0, 1), -1, 1'b1,
						1'b0);
				else
					send_column($urandom_range(2, 12), $urandom_range(0, 3) == 0, -1,
						1'b0, $urandom_range(0, 15) == 0);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_LAYER_SCALE;
		cfg_data = '0;
		in_valid = 1'b0;
		{u_wind, v_wind, w_wind, w_west, w_south} = '0;
		{interface_density, layer_density, layer_thickness, interface_thickness} = '0;
		first_column = 1'b0;
		top_level = 1'b0;
		errors = 0;
		items_sent = 0;
		results_seen = 0;
		columns_sent = 0;
		cycles = 0;
		quiet = 1'b0;
		scale_q = 64'd1 << 32;
		three_d = 1'b1;
		lvl = 0;
		{prev_u, prev_v, prev_w, prev_rhow, prev_layer_f, prev_iface_f} = '0;
		{prev_fu, prev_fv, prev_fw} = '0;
		for (int i = 0; i < NLEV; i++) begin
			u_sums[i] = 0;
			v_sums[i] = 0;
			sum_written[i] = 1'b0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_top_on_bottom();
		test_extremes();
		test_zero_divisor();
		test_config_extremes();
		test_tall_columns();
		test_random_sweeps();
		wait_drained();

		$display("covered %0d levels in %0d columns, %0d results checked",
			items_sent, columns_sent, results_seen);
		if (errors == 0) begin
			$display("PASS vertical_momentum_advection_column");
		end else begin
			$display("%0d mismatches", errors);
			$display("FAIL vertical_momentum_advection_column");
		end
		$finish;
	end

endmodule
